// ===== hw/rtl/bitmap_range_allocator_top_defines.svh =====
// Assertion macros for the bitmap range allocator.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef BITMAP_RANGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_RANGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bra_pkg.sv =====
// Shared types and constants of the bitmap range allocator.
// No dependencies; imported by every allocator module.
package bra_pkg;

    localparam int CHUNKS = 512;
    localparam int ROW_W  = 32;
    localparam int ROWS   = CHUNKS / ROW_W;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int BIT_AW = $clog2(ROW_W);
    localparam int IDX_W  = $clog2(CHUNKS);
    localparam int CNT_W  = 10;
    localparam int ALN_W  = 4;
    localparam int POS_W  = 17;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 24;

    // Request kinds carried on s_tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_HEAD,
        S_RUN,
        S_ROW_RD,
        S_ROW_WR,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_FETCH,
        DP_POS_ADV,
        DP_RUN_BEGIN,
        DP_RUN_NEXT,
        DP_CLASH,
        DP_RETRY,
        DP_RANGE_FREE,
        DP_RANGE_ALLOC,
        DP_ROW_RD,
        DP_ROW_WR,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   probe_run;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic oversize;
        logic single;
        logic retried;
        logic pos_oob;
        logic probe_hit;
        logic probe_used;
        logic run_fits;
        logic run_done;
        logic range_empty;
        logic last_row;
        logic out_room;
    } dp_stat_t;

    // Round a chunk position up to a multiple of 2^aln
    function automatic logic [POS_W-1:0] align_up(input logic [POS_W-1:0] pos,
                                                  input logic [ALN_W-1:0] aln);
        logic [POS_W-1:0] msk;
        msk = (POS_W'(1) << aln) - POS_W'(1);
        return (pos + msk) & ~msk;
    endfunction

endpackage

// ===== hw/rtl/bra_ctrl.sv =====
// Controller of the bitmap range allocator: request sequencing state machine.
// Depends on bra_pkg; drives bra_dp through command and status structs.
module bra_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bra_pkg::dp_stat_t stat,
    output bra_pkg::dp_cmd_t  cmd
);
    import bra_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = DP_NONE;
        cmd.probe_run = 1'b0;
        in_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_free)
                begin
                    cmd.op     = DP_RANGE_FREE;
                    state_next = S_ROW_RD;
                end
                else if (stat.oversize)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (stat.pos_oob || (stat.probe_hit && !stat.probe_used && !stat.run_fits))
                begin
                    // Miss: retry once from chunk zero on a run search
                    if (!stat.single && !stat.retried)
                    begin
                        cmd.op = DP_RETRY;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!stat.probe_hit)
                begin
                    cmd.op = DP_FETCH;
                end
                else if (stat.probe_used)
                begin
                    cmd.op = DP_POS_ADV;
                end
                else
                begin
                    cmd.op     = DP_RUN_BEGIN;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.probe_run = 1'b1;
                if (stat.run_done)
                begin
                    cmd.op     = DP_RANGE_ALLOC;
                    state_next = S_ROW_RD;
                end
                else if (!stat.probe_hit)
                begin
                    cmd.op = DP_FETCH;
                end
                else if (stat.probe_used)
                begin
                    cmd.op     = DP_CLASH;
                    state_next = S_HEAD;
                end
                else
                begin
                    cmd.op = DP_RUN_NEXT;
                end
            end
            S_ROW_RD:
            begin
                if (stat.range_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_ROW_RD;
                    state_next = S_ROW_WR;
                end
            end
            S_ROW_WR:
            begin
                cmd.op = DP_ROW_WR;
                if (stat.last_row)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ROW_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_room)
                begin
                    cmd.op     = DP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bra_dp.sv =====
// Datapath of the bitmap range allocator: used-bit map, search pointers, output register.
// Depends on bra_pkg; commanded by bra_ctrl.
module bra_dp
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_user,
    input  logic [bra_pkg::IN_W-1:0] in_data,
    input  bra_pkg::dp_cmd_t         cmd,
    output bra_pkg::dp_stat_t        stat,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [bra_pkg::OUT_W-1:0] out_data
);
    import bra_pkg::*;

    // Used-bit map, one row per word, with a valid bit per row
    logic [ROW_W-1:0]  mem [ROWS];
    logic [ROWS-1:0]   row_vld_reg;
    logic [ROW_W-1:0]  rdata_reg;
    logic              rvalid_reg;

    // Request and search registers
    logic              op_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ALN_W-1:0]  aln_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              retried_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [ROW_AW-1:0] row_reg;
    logic [ROW_AW-1:0] last_row_reg;
    logic              cache_vld_reg;
    logic [ROW_AW-1:0] cache_row_reg;

    // Persistent allocator state
    logic [IDX_W-1:0]  ss_reg;
    logic [CNT_W-1:0]  fc_reg;
    logic [IDX_W-1:0]  ss_next;
    logic [CNT_W-1:0]  fc_next;

    // Output register
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [IDX_W-1:0]  probe;
    logic [ROW_AW-1:0] probe_row;
    logic [ROW_W-1:0]  row_data;
    logic [CNT_W:0]    run_end;
    logic [CNT_W:0]    free_end;
    logic [CNT_W-1:0]  free_hi;
    logic [CNT_W-1:0]  hi_m1;
    logic [CNT_W-1:0]  alloc_hi_m1;
    logic [ROW_W-1:0]  mask;
    logic [ROW_W-1:0]  wdata;
    logic              single;
    logic [POS_W-1:0]  aln_val;
    logic [ROW_AW-1:0] rd_row;
    logic              rd_en;
    logic              ok_next;
    logic [IDX_W-1:0]  start_next;
    logic [CNT_W:0]    fc_sum;
    logic [CNT_W-1:0]  ss_sum;

    // Request fields: op from in_user; in_data low bits first: count, align_log2, base
    logic              in_op;
    logic [CNT_W-1:0]  in_count;
    logic [ALN_W-1:0]  in_aln;
    logic [IDX_W-1:0]  in_base;

    assign in_op    = in_user;
    assign in_count = in_data[CNT_W-1:0];
    assign in_aln   = in_data[CNT_W+ALN_W-1:CNT_W];
    assign in_base  = in_data[CNT_W+ALN_W+IDX_W-1:CNT_W+ALN_W];

    // Probe address and cached row lookup
    assign single    = (count_reg == CNT_W'(1)) && (aln_reg == '0);
    assign aln_val   = POS_W'(1) << aln_reg;
    assign probe     = cmd.probe_run ? idx_reg[IDX_W-1:0] : pos_reg[IDX_W-1:0];
    assign probe_row = probe[IDX_W-1:BIT_AW];
    assign row_data  = rvalid_reg ? rdata_reg : '0;
    assign run_end   = (CNT_W+1)'(pos_reg[CNT_W-1:0]) + (CNT_W+1)'(count_reg);
    assign free_end  = (CNT_W+1)'(base_reg) + (CNT_W+1)'(count_reg);
    assign free_hi   = (free_end > (CNT_W+1)'(CHUNKS)) ? CNT_W'(CHUNKS) : free_end[CNT_W-1:0];
    assign hi_m1     = free_hi - CNT_W'(1);
    assign alloc_hi_m1 = run_end[CNT_W-1:0] - CNT_W'(1);

    // Status to the controller
    always_comb
    begin
        stat.is_free     = (op_reg == OP_FREE);
        stat.oversize    = count_reg > CNT_W'(CHUNKS);
        stat.single      = single;
        stat.retried     = retried_reg;
        stat.pos_oob     = pos_reg >= POS_W'(CHUNKS);
        stat.probe_hit   = cache_vld_reg && (cache_row_reg == probe_row);
        stat.probe_used  = row_data[probe[BIT_AW-1:0]];
        stat.run_fits    = ((POS_W+1)'(pos_reg) + (POS_W+1)'(count_reg)) <= (POS_W+1)'(CHUNKS);
        stat.run_done    = (CNT_W+1)'(idx_reg) >= run_end;
        stat.range_empty = hi_reg <= lo_reg;
        stat.last_row    = row_reg == last_row_reg;
        stat.out_room    = !out_valid_reg || out_ready;
    end

    // Bit mask of the range [lo, hi) within the current row
    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            mask[b] = ({1'b0, row_reg, BIT_AW'(b)} >= lo_reg) &&
                      ({1'b0, row_reg, BIT_AW'(b)} < hi_reg);
        end
        wdata = (op_reg == OP_FREE) ? (row_data & ~mask) : (row_data | mask);
    end

    // Memory read port select
    assign rd_en  = (cmd.op == DP_FETCH) || (cmd.op == DP_ROW_RD);
    assign rd_row = (cmd.op == DP_ROW_RD) ? row_reg : probe_row;

    // Map memory: write a row back, read a row into the data register
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_ROW_WR)
        begin
            mem[row_reg] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_row];
        end
    end

    // Row valid bits and read-side row valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            rvalid_reg    <= 1'b0;
            cache_vld_reg <= 1'b0;
            cache_row_reg <= '0;
        end
        else
        begin
            if (cmd.op == DP_ROW_WR)
            begin
                row_vld_reg[row_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg    <= row_vld_reg[rd_row];
                cache_vld_reg <= 1'b1;
                cache_row_reg <= rd_row;
            end
            else if (cmd.op == DP_LOAD || cmd.op == DP_ROW_WR)
            begin
                cache_vld_reg <= 1'b0;
            end
        end
    end

    // Request and search registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                op_reg      <= in_op;
                count_reg   <= in_count;
                aln_reg     <= in_aln;
                base_reg    <= in_base;
                retried_reg <= 1'b0;
                hit_reg     <= 1'b0;
                if ((in_count == CNT_W'(1)) && (in_aln == '0))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= align_up(POS_W'(ss_reg), in_aln);
                end
            end
            DP_RETRY:
            begin
                pos_reg     <= '0;
                retried_reg <= 1'b1;
            end
            DP_POS_ADV:
            begin
                pos_reg <= pos_reg + aln_val;
            end
            DP_RUN_BEGIN:
            begin
                idx_reg <= pos_reg[CNT_W-1:0] + CNT_W'(1);
            end
            DP_RUN_NEXT:
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            DP_CLASH:
            begin
                pos_reg <= align_up(POS_W'(idx_reg) + POS_W'(1), aln_reg);
            end
            DP_RANGE_FREE:
            begin
                lo_reg       <= CNT_W'(base_reg);
                hi_reg       <= free_hi;
                row_reg      <= base_reg[IDX_W-1:BIT_AW];
                last_row_reg <= hi_m1[IDX_W-1:BIT_AW];
            end
            DP_RANGE_ALLOC:
            begin
                hit_reg      <= 1'b1;
                lo_reg       <= pos_reg[CNT_W-1:0];
                hi_reg       <= run_end[CNT_W-1:0];
                row_reg      <= pos_reg[IDX_W-1:BIT_AW];
                last_row_reg <= alloc_hi_m1[IDX_W-1:BIT_AW];
            end
            DP_ROW_WR:
            begin
                row_reg <= row_reg + ROW_AW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Pointer, free count and result of the finished request
    always_comb
    begin
        ss_next    = ss_reg;
        fc_next    = fc_reg;
        ok_next    = 1'b0;
        start_next = '0;
        fc_sum     = (CNT_W+1)'(fc_reg) + (CNT_W+1)'(count_reg);
        ss_sum     = CNT_W'(pos_reg[IDX_W-1:0]) + count_reg;
        if (op_reg == OP_FREE)
        begin
            ok_next = 1'b1;
            if (base_reg < ss_reg)
            begin
                ss_next = base_reg;
            end
            fc_next = (fc_sum > (CNT_W+1)'(CHUNKS)) ? CNT_W'(CHUNKS) : fc_sum[CNT_W-1:0];
        end
        else if (hit_reg)
        begin
            ok_next    = 1'b1;
            start_next = pos_reg[IDX_W-1:0];
            fc_next    = (fc_reg >= count_reg) ? fc_reg - count_reg : '0;
            if (single)
            begin
                ss_next = pos_reg[IDX_W-1:0] + IDX_W'(1);
            end
            else if (pos_reg[IDX_W-1:0] == ss_reg)
            begin
                ss_next = (ss_sum >= CNT_W'(CHUNKS)) ? '0 : ss_sum[IDX_W-1:0];
            end
        end
    end

    // Allocator state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg        <= '0;
            fc_reg        <= CNT_W'(CHUNKS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == DP_FINISH)
            begin
                ss_reg        <= ss_next;
                fc_reg        <= fc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: ok, start_chunk, chunks_free, pool_empty
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_FINISH)
        begin
            out_data_reg <= OUT_W'({(fc_next == CNT_W'(CHUNKS)), fc_next, start_next, ok_next});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/bitmap_range_allocator_top.sv =====
// Bitmap range allocator: first-fit aligned run allocator over 512 chunks.
// Usage: one request enters on the s_ side (op on s_tuser; count,
// align_log2 and base on s_tdata). The request is searched, then the map
// is updated and one result transfer leaves on the m_ side
// (ok, start_chunk, chunks_free, pool_empty).
// A free reads and writes back each touched 32-chunk row in turn.
// An allocate scans the map one chunk per cycle through a cached row
// word, pausing for each row fetch, from the search pointer and once
// more from chunk zero on a miss; it then reads and writes back each
// marked row in turn and finishes.
// One request is in work at a time; s_tready is high only when idle.
// A finished result waits in the output register while the next request
// is taken; when the receiver stalls, the block holds in its final step
// until the output register frees.
// Reset empties the map at once (row valid bits), zeroes the search
// pointer and sets the free count to 512; no clearing pass is needed.
// Depends on bra_pkg, bra_ctrl and bra_dp.
module bitmap_range_allocator_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // op[0]
    input  logic                      s_tuser,
    // count[9:0], align_log2[13:10], base[22:14], zero[23]
    input  logic [bra_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // ok[0], start_chunk[9:1], chunks_free[19:10], pool_empty[20], zero[23:21]
    output logic [bra_pkg::OUT_W-1:0] m_tdata
);
    import bra_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence requests
    bra_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the map, pointers and result
    bra_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_user   (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== hw/rtl/bra_checker.sv =====
// Port checker of the bitmap range allocator, bound to the top level.
// Depends on bra_pkg and bitmap_range_allocator_top_defines.svh.
`include "bitmap_range_allocator_top_defines.svh"

module bra_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [bra_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [bra_pkg::OUT_W-1:0] m_tdata
);
    import bra_pkg::*;

    // Stalled result holds
    `BRA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Failed result (ok clear) carries no start chunk
    `BRA_ASSERT_NOW(a_fail_zero, m_tvalid && !m_tdata[0], m_tdata[9:1] == '0, "failed result has a start chunk")

    // Empty flag matches the free count
    `BRA_ASSERT_NOW(a_empty, m_tvalid, m_tdata[20] == (m_tdata[19:10] == 10'(CHUNKS)), "pool_empty disagrees with chunks_free")

    // Free count never exceeds the pool
    `BRA_ASSERT_NOW(a_fc_max, m_tvalid, m_tdata[19:10] <= 10'(CHUNKS), "chunks_free above pool size")

endmodule

bind bitmap_range_allocator_top bra_checker u_bra_checker (.*);

// ===== verif/bitmap_range_allocator_top_test.sv =====
// Self-checking bench for bitmap_range_allocator_top: directed table, then random
// allocate/free traffic checked against an in-bench first-fit model.
// Depends on bra_pkg and the allocator RTL.
module bitmap_range_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bra_pkg::*;

    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   RANDOM_ITEMS   = 1930;

    typedef struct packed {
        logic [8:0] base;
        logic [3:0] align_log2;
        logic [9:0] count;
        logic       op;
    } request_t;

    typedef struct packed {
        logic [2:0] zero;
        logic       pool_empty;
        logic [9:0] chunks_free;
        logic [8:0] start_chunk;
        logic       ok;
    } grant_t;

    typedef struct {
        request_t req;
        logic     known;
        grant_t   grant;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic                s_tuser;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    bit              chunk_used[CHUNKS];
    int unsigned     next_search;
    int unsigned     free_count;
    grant_t          pending_grants[$];
    int              mismatch_count;
    int              grant_count;
    int              idle_cycles = 0;
    int              stall_left = 0;
    int              alloc_ok_count;
    int              free_req_count;
    bit              stim_done;
    row_t            directed_rows[$];

    bitmap_range_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Generate a 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Search for an aligned free run starting at from_pos
    function automatic bit locate_run(input int unsigned from_pos, input int unsigned len,
                                      input int unsigned alignment, output int unsigned found);
        longint unsigned pos;
        bit clash;
        pos = from_pos;
        found = 0;
        forever
        begin
            clash = 1'b0;
            pos = (pos + alignment - 1) & ~(longint'(alignment) - 1);
            while (pos < CHUNKS && chunk_used[pos])
                pos += alignment;
            if (pos >= CHUNKS)
                return 1'b0;
            if (pos + len > CHUNKS)
                return 1'b0;
            for (longint unsigned i = pos + 1; i < pos + len; i++)
            begin
                if (chunk_used[i])
                begin
                    pos = i + 1;
                    clash = 1'b1;
                    break;
                end
            end
            if (!clash)
            begin
                found = 32'(pos);
                return 1'b1;
            end
        end
    endfunction

    // Apply one request to the allocator state and return the grant
    function automatic grant_t allocate_or_free(input request_t req);
        grant_t g;
        int unsigned i;
        int unsigned pos;
        int unsigned first;
        bit hit;
        g = '0;
        if (req.op == OP_ALLOC)
        begin
            if (req.count == 1 && req.align_log2 == 0)
            begin
                for (i = 0; i < CHUNKS; i++)
                    if (!chunk_used[i])
                        break;
                if (i < CHUNKS)
                begin
                    chunk_used[i] = 1'b1;
                    next_search = (i + 1 == CHUNKS) ? 0 : i + 1;
                    if (free_count > 0)
                        free_count--;
                    g.ok = 1'b1;
                    g.start_chunk = i[8:0];
                end
            end
            else if (req.count <= CHUNKS)
            begin
                hit = locate_run(next_search, req.count, 1 << req.align_log2, pos);
                if (!hit)
                    hit = locate_run(0, req.count, 1 << req.align_log2, pos);
                if (hit)
                begin
                    for (i = 0; i < req.count; i++)
                        chunk_used[pos + i] = 1'b1;
                    if (pos == next_search)
                    begin
                        next_search = pos + req.count;
                        if (next_search >= CHUNKS)
                            next_search = 0;
                    end
                    free_count = (free_count >= req.count) ? free_count - req.count : 0;
                    g.ok = 1'b1;
                    g.start_chunk = pos[8:0];
                end
            end
        end
        else
        begin
            first = req.base % CHUNKS;
            for (i = 0; i < req.count; i++)
                if (first + i < CHUNKS)
                    chunk_used[first + i] = 1'b0;
            if (first < next_search)
                next_search = first;
            free_count += req.count;
            if (free_count > CHUNKS)
                free_count = CHUNKS;
            g.ok = 1'b1;
        end
        g.chunks_free = free_count[9:0];
        g.pool_empty = (free_count == CHUNKS);
        if (g.ok && req.op == OP_ALLOC)
            alloc_ok_count++;
        if (req.op == OP_FREE)
            free_req_count++;
        return g;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request and record its expected grant
    task automatic send_request(input request_t req, input logic known, input grant_t typed);
        grant_t g;
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= IN_W'({req.base, req.align_log2, req.count});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = allocate_or_free(req);
        if (known && g != typed)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Directed table row disagrees with predictor: typed %h predicted %h",
                         typed, g);
        end
        pending_grants.push_back(g);
    endtask

    function automatic request_t make_req(input logic op, input int count, input int aln,
                                          input int base);
        request_t r;
        r.op = op;
        r.count = count[9:0];
        r.align_log2 = aln[3:0];
        r.base = base[8:0];
        return r;
    endfunction

    function automatic grant_t make_grant(input int ok, input int start, input int nfree);
        grant_t g;
        g = '0;
        g.ok = ok[0];
        g.start_chunk = start[8:0];
        g.chunks_free = nfree[9:0];
        g.pool_empty = (nfree == CHUNKS);
        return g;
    endfunction

    task automatic add_row(input request_t req, input logic known, input grant_t g);
        row_t r;
        r.req = req;
        r.known = known;
        r.grant = g;
        directed_rows.push_back(r);
    endtask

    function automatic request_t random_request();
        request_t r;
        int k;
        k = $urandom_range(0, 99);
        r = request_t'($urandom);
        if (k < 45)
        begin
            r.op = OP_ALLOC;
            r.count = 10'($urandom_range(0, 99) < 80 ? $urandom_range(1, 24)
                                                     : $urandom_range(0, 1023));
            r.align_log2 = 4'($urandom_range(0, 99) < 85 ? $urandom_range(0, 4)
                                                         : $urandom_range(0, 15));
        end
        else if (k < 55)
        begin
            r.op = OP_ALLOC;
            r.count = 10'd1;
            r.align_log2 = 4'd0;
        end
        else if (k < 92)
        begin
            r.op = OP_FREE;
            r.count = 10'($urandom_range(0, 99) < 85 ? $urandom_range(0, 24)
                                                     : $urandom_range(0, 1023));
        end
        return r;
    endfunction

    // Receive and check grants with random stalls, mostly short and a few long
    always @(posedge clk or negedge rst_n)
    begin
        grant_t got;
        grant_t want;
        int pick;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = grant_t'(m_tdata);
                grant_count++;
                if (pending_grants.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected grant %h", got);
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (got != want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Grant mismatch: ok %0d/%0d start %0d/%0d free %0d/%0d %s %0d/%0d zero %0d",
                                     want.ok, got.ok, want.start_chunk, got.start_chunk,
                                     want.chunks_free, got.chunks_free, "empty",
                                     want.pool_empty, got.pool_empty, got.zero);
                    end
                end
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 90)
                begin
                    m_tready <= 1'b1;
                end
                else
                begin
                    m_tready <= 1'b0;
                    stall_left = (pick < 98) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int drain;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        mismatch_count = 0;
        grant_count = 0;
        alloc_ok_count = 0;
        free_req_count = 0;
        stim_done = 1'b0;
        next_search = 0;
        free_count = CHUNKS;
        for (int i = 0; i < CHUNKS; i++)
            chunk_used[i] = 1'b0;

        // Directed table: after reset, extremes and special cases
        add_row(make_req(OP_ALLOC, 1, 0, 0), 1, make_grant(1, 0, 511));
        add_row(make_req(OP_ALLOC, 1, 0, 511), 1, make_grant(1, 1, 510));
        add_row(make_req(OP_FREE, 2, 0, 0), 1, make_grant(1, 0, 512));
        add_row(make_req(OP_ALLOC, 513, 0, 0), 1, make_grant(0, 0, 512));
        add_row(make_req(OP_ALLOC, 1023, 15, 0), 1, make_grant(0, 0, 512));
        add_row(make_req(OP_ALLOC, 512, 0, 0), 1, make_grant(1, 0, 0));
        add_row(make_req(OP_ALLOC, 1, 0, 0), 1, make_grant(0, 0, 0));
        add_row(make_req(OP_ALLOC, 0, 3, 0), 1, make_grant(0, 0, 0));
        add_row(make_req(OP_FREE, 1023, 15, 511), 1, make_grant(1, 0, 512));
        add_row(make_req(OP_FREE, 512, 0, 0), 1, make_grant(1, 0, 512));
        add_row(make_req(OP_ALLOC, 0, 0, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 5, 9, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 3, 15, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 7, 2, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 7, 2, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 1, 1, 0), 0, '0);
        add_row(make_req(OP_FREE, 0, 0, 300), 0, '0);
        add_row(make_req(OP_ALLOC, 40, 4, 0), 0, '0);
        add_row(make_req(OP_FREE, 3, 0, 4), 0, '0);
        add_row(make_req(OP_ALLOC, 2, 0, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 300, 0, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 511, 0, 0), 0, '0);
        add_row(make_req(OP_FREE, 512, 0, 0), 0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].grant);

        // Random traffic, with one full drain partway through
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_grants.size() != 0)
                    @(posedge clk);
            end
            send_request(random_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (pending_grants.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 2200)
        begin
            @(posedge clk);
            drain++;
        end

        $display("Ran %0d requests (%0d granted allocates, %0d frees); %0d grants checked.",
                 directed_rows.size() + RANDOM_ITEMS, alloc_ok_count, free_req_count,
                 grant_count);
        $display("Covered first-fit, aligned, oversized, zero-count and past-end cases.");
        if (mismatch_count == 0 && pending_grants.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
